@@ rtl/ucc_pkg.sv @@
package ucc_pkg;

  localparam int unsigned EPOCH_YEAR = 1970;
  localparam int unsigned MAX_YEAR   = 2105;
  // latest year that 32-bit epoch seconds can reach
  localparam int unsigned LAST_YEAR  = 2106;

  localparam logic [16:0] SECS_PER_DAY  = 17'd86400;
  localparam logic [11:0] SECS_PER_HOUR = 12'd3600;
  localparam logic [5:0]  SECS_PER_MIN  = 6'd60;

  // reciprocals for the divisions by constants, applied once the power-of-two
  // part of the divisor is shifted out: 86400 = 675 << 7, 3600 = 225 << 4,
  // 60 = 15 << 2
  localparam logic [25:0] RCP_DAY  = 26'd50903317;  // ceil(2^35 / 675)
  localparam logic [13:0] RCP_HOUR = 14'd9321;      // ceil(2^21 / 225)
  localparam logic [10:0] RCP_MIN  = 11'd1093;      // ceil(2^14 / 15)

  // 1970 taken modulo 4, 100 and 400
  localparam logic [1:0] EPOCH_MOD4   = 2'd2;
  localparam logic [6:0] EPOCH_MOD100 = 7'd70;
  localparam logic [8:0] EPOCH_MOD400 = 9'd370;

  localparam logic CMD_TO_CAL  = 1'b0;
  localparam logic CMD_TO_SECS = 1'b1;

  typedef enum logic [1:0] {
    DIV_DAY  = 2'd0,
    DIV_HOUR = 2'd1,
    DIV_MIN  = 2'd2
  } ucc_div_t;

  typedef struct packed {
    logic     load;
    logic     div_step;
    ucc_div_t div_sel;
    logic     year_step;
    logic     month_step;
    logic     mul;
    logic     load_out;
  } ucc_cmd_t;

  typedef struct packed {
    logic cmd;
    logic err;
    logic div_last;
    logic year_more;
    logic month_more;
  } ucc_stat_t;

  // days of month m0 (0 = January)
  function automatic logic [4:0] month_days(input logic [3:0] m0, input logic leap);
    logic [4:0] d;
    case (m0)
      4'd1:                         d = leap ? 5'd29 : 5'd28;
      4'd3, 4'd5, 4'd8, 4'd10:      d = 5'd30;
      default:                      d = 5'd31;
    endcase
    return d;
  endfunction

endpackage

@@ rtl/ucc_if.sv @@
interface ucc_in_if;
  logic        valid;
  logic        ready;
  logic        command;
  logic [31:0] epoch_seconds;
  logic [11:0] year_in;
  logic [3:0]  month_in;
  logic [4:0]  day_in;
  logic [4:0]  hour_in;
  logic [5:0]  minute_in;
  logic [5:0]  second_in;

  modport source (
    output valid, command, epoch_seconds, year_in, month_in, day_in, hour_in,
           minute_in, second_in,
    input  ready
  );
  modport sink (
    input  valid, command, epoch_seconds, year_in, month_in, day_in, hour_in,
           minute_in, second_in,
    output ready
  );
endinterface

interface ucc_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] epoch_seconds_out;
  logic [11:0] year_out;
  logic [3:0]  month_out;
  logic [4:0]  day_out;
  logic [4:0]  hour_out;
  logic [5:0]  minute_out;
  logic [5:0]  second_out;
  logic        range_error;

  modport source (
    output valid, epoch_seconds_out, year_out, month_out, day_out, hour_out,
           minute_out, second_out, range_error,
    input  ready
  );
  modport sink (
    input  valid, epoch_seconds_out, year_out, month_out, day_out, hour_out,
           minute_out, second_out, range_error,
    output ready
  );
endinterface

@@ rtl/unix_time_calendar_converter.sv @@
// Converts Unix epoch seconds to a Gregorian date and time of day (command 0)
// or a date and time back to epoch seconds (command 1), one item at a time.
// The work for an item grows with Y, the number of years walked from 1970 (up
// to 136), and M, the number of months walked (up to 11). It is set by the
// three divisions by constants (command 0 only; each is a reciprocal multiply
// for the quotient, then the remainder) and by the year and month walks, which
// advance one year or one month per cycle. The next item is taken only once the
// controller is back in idle. A year outside 1970..2105 or a month outside 1..12
// on command 1 returns only range_error. The result sits in an output register,
// so the next item is taken while a finished result still waits.
module unix_time_calendar_converter import ucc_pkg::*; (
  input logic         clk,
  input logic         rst_n,
  ucc_in_if.sink      in_ch,
  ucc_out_if.source   out_ch
);

  ucc_cmd_t  cmd;
  ucc_stat_t stat;

  ucc_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ch.ready),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .stat      (stat),
    .cmd       (cmd)
  );

  ucc_datapath u_datapath (
    .clk               (clk),
    .rst_n             (rst_n),
    .cmd               (cmd),
    .stat              (stat),
    .command           (in_ch.command),
    .epoch_seconds     (in_ch.epoch_seconds),
    .year_in           (in_ch.year_in),
    .month_in          (in_ch.month_in),
    .day_in            (in_ch.day_in),
    .hour_in           (in_ch.hour_in),
    .minute_in         (in_ch.minute_in),
    .second_in         (in_ch.second_in),
    .epoch_seconds_out (out_ch.epoch_seconds_out),
    .year_out          (out_ch.year_out),
    .month_out         (out_ch.month_out),
    .day_out           (out_ch.day_out),
    .hour_out          (out_ch.hour_out),
    .minute_out        (out_ch.minute_out),
    .second_out        (out_ch.second_out),
    .range_error       (out_ch.range_error)
  );

endmodule

@@ rtl/ucc_datapath.sv @@
module ucc_datapath import ucc_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  ucc_cmd_t    cmd,
  output ucc_stat_t   stat,
  input  logic        command,
  input  logic [31:0] epoch_seconds,
  input  logic [11:0] year_in,
  input  logic [3:0]  month_in,
  input  logic [4:0]  day_in,
  input  logic [4:0]  hour_in,
  input  logic [5:0]  minute_in,
  input  logic [5:0]  second_in,
  output logic [31:0] epoch_seconds_out,
  output logic [11:0] year_out,
  output logic [3:0]  month_out,
  output logic [4:0]  day_out,
  output logic [4:0]  hour_out,
  output logic [5:0]  minute_out,
  output logic [5:0]  second_out,
  output logic        range_error
);

  logic        cmd_r;
  logic        err_r;
  logic [11:0] year_tgt_r;
  logic [3:0]  month_tgt_r;
  logic [4:0]  day_r;
  logic [4:0]  hour_r;
  logic [5:0]  minute_r;
  logic [5:0]  second_r;
  logic [31:0] rem_r;
  logic [15:0] quo_r;
  // 1 = quotient step, 0 = remainder step
  logic        cnt_r;
  logic [15:0] days_r;
  logic [11:0] year_r;
  logic [1:0]  mod4_r;
  logic [6:0]  mod100_r;
  logic [8:0]  mod400_r;
  logic [3:0]  mon_r;
  logic [31:0] prod_r;

  logic [31:0] epoch_o_r;
  logic [11:0] year_o_r;
  logic [3:0]  month_o_r;
  logic [4:0]  day_o_r;
  logic [4:0]  hour_o_r;
  logic [5:0]  minute_o_r;
  logic [5:0]  second_o_r;
  logic        range_o_r;

  logic [16:0] dvs;
  logic [50:0] qmul_day;
  logic [26:0] qmul_hour;
  logic [20:0] qmul_min;
  logic [31:0] rem_nxt;
  logic [15:0] quo_nxt;
  logic        leap;
  logic [8:0]  ylen;
  logic [4:0]  dim;
  logic        load_err;
  logic [31:0] dsum;
  logic [31:0] tod;

  // division by a constant: quotient by reciprocal multiply, remainder next cycle
  assign qmul_day  = 51'(rem_r[31:7]) * 51'(RCP_DAY);
  assign qmul_hour = 27'(rem_r[16:4]) * 27'(RCP_HOUR);
  assign qmul_min  = 21'(rem_r[11:2]) * 21'(RCP_MIN);

  always_comb begin
    case (cmd.div_sel)
      DIV_DAY: begin
        dvs     = SECS_PER_DAY;
        quo_nxt = qmul_day[50:35];
      end
      DIV_HOUR: begin
        dvs     = 17'(SECS_PER_HOUR);
        quo_nxt = 16'(qmul_hour[26:21]);
      end
      DIV_MIN: begin
        dvs     = 17'(SECS_PER_MIN);
        quo_nxt = 16'(qmul_min[20:14]);
      end
      default: begin
        dvs     = SECS_PER_DAY;
        quo_nxt = qmul_day[50:35];
      end
    endcase
    rem_nxt = rem_r - 32'(quo_r) * 32'(dvs);
  end

  assign leap = ((mod4_r == 2'd0) && (mod100_r != 7'd0)) || (mod400_r == 9'd0);
  assign ylen = leap ? 9'd366 : 9'd365;
  assign dim  = month_days(mon_r, leap);

  assign load_err = (command == CMD_TO_SECS) &&
                    ((year_in < 12'(EPOCH_YEAR)) || (year_in > 12'(MAX_YEAR)) ||
                     (month_in < 4'd1) || (month_in > 4'd12));

  assign dsum = 32'(days_r) + 32'(day_r) - 32'd1;
  assign tod  = 32'(hour_r) * 32'(SECS_PER_HOUR) + 32'(minute_r) * 32'(SECS_PER_MIN) +
                32'(second_r);

  always_comb begin
    stat.cmd      = cmd_r;
    stat.err      = err_r;
    stat.div_last = !cnt_r;
    if (cmd_r == CMD_TO_CAL) begin
      stat.year_more  = days_r >= 16'(ylen);
      stat.month_more = (mon_r < 4'd11) && (days_r >= 16'(dim));
    end else begin
      stat.year_more  = year_r < year_tgt_r;
      stat.month_more = (5'(mon_r) + 5'd1) < 5'(month_tgt_r);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      cmd_r       <= command;
      err_r       <= load_err;
      year_tgt_r  <= year_in;
      month_tgt_r <= month_in;
      day_r       <= day_in;
      hour_r      <= hour_in;
      minute_r    <= minute_in;
      second_r    <= second_in;
      rem_r       <= epoch_seconds;
      cnt_r       <= 1'b1;
      days_r      <= 16'd0;
      year_r      <= 12'(EPOCH_YEAR);
      mod4_r      <= EPOCH_MOD4;
      mod100_r    <= EPOCH_MOD100;
      mod400_r    <= EPOCH_MOD400;
      mon_r       <= 4'd0;
    end

    if (cmd.div_step) begin
      if (cnt_r) begin
        quo_r <= quo_nxt;
        cnt_r <= 1'b0;
      end else begin
        rem_r <= rem_nxt;
        cnt_r <= 1'b1;
        case (cmd.div_sel)
          DIV_DAY:  days_r <= quo_r;
          DIV_HOUR: hour_r <= quo_r[4:0];
          DIV_MIN: begin
            minute_r <= quo_r[5:0];
            second_r <= rem_nxt[5:0];
          end
          default: ;
        endcase
      end
    end

    if (cmd.year_step) begin
      days_r   <= (cmd_r == CMD_TO_CAL) ? days_r - 16'(ylen) : days_r + 16'(ylen);
      year_r   <= year_r + 12'd1;
      mod4_r   <= mod4_r + 2'd1;
      mod100_r <= (mod100_r == 7'd99) ? 7'd0 : mod100_r + 7'd1;
      mod400_r <= (mod400_r == 9'd399) ? 9'd0 : mod400_r + 9'd1;
    end

    if (cmd.month_step) begin
      days_r <= (cmd_r == CMD_TO_CAL) ? days_r - 16'(dim) : days_r + 16'(dim);
      mon_r  <= mon_r + 4'd1;
    end

    if (cmd.mul) begin
      prod_r <= dsum * 32'(SECS_PER_DAY);
    end

    if (cmd.load_out) begin
      if (cmd_r == CMD_TO_CAL) begin
        epoch_o_r  <= 32'd0;
        year_o_r   <= year_r;
        month_o_r  <= mon_r + 4'd1;
        day_o_r    <= days_r[4:0] + 5'd1;
        hour_o_r   <= hour_r;
        minute_o_r <= minute_r;
        second_o_r <= second_r;
        range_o_r  <= year_r > 12'(MAX_YEAR);
      end else begin
        epoch_o_r  <= err_r ? 32'd0 : prod_r + tod;
        year_o_r   <= 12'd0;
        month_o_r  <= 4'd0;
        day_o_r    <= 5'd0;
        hour_o_r   <= 5'd0;
        minute_o_r <= 6'd0;
        second_o_r <= 6'd0;
        range_o_r  <= err_r;
      end
    end
  end

  assign epoch_seconds_out = epoch_o_r;
  assign year_out          = year_o_r;
  assign month_out         = month_o_r;
  assign day_out           = day_o_r;
  assign hour_out          = hour_o_r;
  assign minute_out        = minute_o_r;
  assign second_out        = second_o_r;
  assign range_error       = range_o_r;

  a_day_rem: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.div_step && cmd.div_sel == DIV_DAY && !cnt_r) |=>
      (rem_r < 32'(SECS_PER_DAY)))
    else $error("time of day remainder not below one day");

  a_year_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.year_step |-> (year_r < 12'(LAST_YEAR)))
    else $error("year walk ran past the last reachable year");

  a_month_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.month_step |-> (mon_r < 4'd11))
    else $error("month walk ran past December");

endmodule

@@ rtl/ucc_ctrl.sv @@
module ucc_ctrl import ucc_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_ready,
  output logic      out_valid,
  input  logic      out_ready,
  input  ucc_stat_t stat,
  output ucc_cmd_t  cmd
);

  typedef enum logic [8:0] {
    S_IDLE  = 9'b000000001,
    S_START = 9'b000000010,
    S_DDAY  = 9'b000000100,
    S_DHOUR = 9'b000001000,
    S_DMIN  = 9'b000010000,
    S_YEAR  = 9'b000100000,
    S_MONTH = 9'b001000000,
    S_MUL   = 9'b010000000,
    S_DONE  = 9'b100000000
  } ucc_state_t;

  ucc_state_t state_r, state_nxt;
  logic       out_valid_r, out_valid_nxt;

  always_comb begin
    cmd       = '0;
    state_nxt = state_r;
    in_ready  = (state_r == S_IDLE);
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = S_START;
        end
      end
      S_START: begin
        if (stat.cmd == CMD_TO_CAL) begin
          state_nxt = S_DDAY;
        end else if (stat.err) begin
          state_nxt = S_DONE;
        end else begin
          state_nxt = S_YEAR;
        end
      end
      S_DDAY: begin
        cmd.div_step = 1'b1;
        cmd.div_sel  = DIV_DAY;
        if (stat.div_last) state_nxt = S_DHOUR;
      end
      S_DHOUR: begin
        cmd.div_step = 1'b1;
        cmd.div_sel  = DIV_HOUR;
        if (stat.div_last) state_nxt = S_DMIN;
      end
      S_DMIN: begin
        cmd.div_step = 1'b1;
        cmd.div_sel  = DIV_MIN;
        if (stat.div_last) state_nxt = S_YEAR;
      end
      S_YEAR: begin
        if (stat.year_more) begin
          cmd.year_step = 1'b1;
        end else begin
          state_nxt = S_MONTH;
        end
      end
      S_MONTH: begin
        if (stat.month_more) begin
          cmd.month_step = 1'b1;
        end else begin
          state_nxt = (stat.cmd == CMD_TO_CAL) ? S_DONE : S_MUL;
        end
      end
      S_MUL: begin
        cmd.mul   = 1'b1;
        state_nxt = S_DONE;
      end
      S_DONE: begin
        // wait for the output register to free up
        if (!out_valid_r || out_ready) begin
          cmd.load_out = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
    out_valid_nxt = cmd.load_out | (out_valid_r & ~out_ready);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_valid = out_valid_r;

  a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> !in_ready)
    else $error("second item taken while one is in work");

  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_ready) |=> !cmd.load_out || !$past(cmd.load_out))
    else $error("pending result overwritten");

  a_result_shown: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.load_out |=> out_valid)
    else $error("loaded result not presented");

endmodule

@@ sim/tb_unix_time_calendar_converter.sv @@
`timescale 1ns / 100ps

module tb_unix_time_calendar_converter import ucc_pkg::*; ();

  localparam int unsigned RANDOM_ITEMS = 1350;
  localparam int unsigned LIMIT_CYCLES = 3_000_000;
  localparam int unsigned DRAIN_CYCLES = 200;
  localparam int unsigned HOLD_AFTER   = 300;
  localparam int unsigned HOLD_CYCLES  = 1500;
  localparam int unsigned MONTH_DAYS [12] = '{31, 28, 31, 30, 31, 30, 31, 31, 30, 31, 30, 31};

  typedef struct packed {
    logic        command;
    logic [31:0] secs;
    logic [11:0] year;
    logic [3:0]  month;
    logic [4:0]  day;
    logic [4:0]  hour;
    logic [5:0]  minute;
    logic [5:0]  second;
  } cal_req_t;

  typedef struct packed {
    logic [31:0] secs;
    logic [11:0] year;
    logic [3:0]  month;
    logic [4:0]  day;
    logic [4:0]  hour;
    logic [5:0]  minute;
    logic [5:0]  second;
    logic        range_error;
  } cal_res_t;

  typedef struct {
    cal_req_t req;
    bit       has_exp;
    cal_res_t res;
  } dir_row_t;

  logic clk;
  logic rst_n;

  ucc_in_if  in_ch ();
  ucc_out_if out_ch ();

  cal_res_t    due_conversions[$];
  int unsigned items_accepted = 0;
  int unsigned mismatches = 0;
  int unsigned cycle_cnt = 0;
  bit          calm = 1'b0;

  unix_time_calendar_converter u_dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  function automatic bit leap_year(int unsigned y);
    return ((y % 4) == 0 && (y % 100) != 0) || ((y % 400) == 0);
  endfunction

  function automatic int unsigned days_in_year(int unsigned y);
    return leap_year(y) ? 366 : 365;
  endfunction

  function automatic int unsigned days_in_month(int unsigned m0, int unsigned y);
    if (m0 == 1 && leap_year(y)) return 29;
    return MONTH_DAYS[m0 % 12];
  endfunction

  function automatic cal_res_t convert_time(cal_req_t r);
    cal_res_t    res;
    int unsigned s;
    int unsigned days;
    int unsigned y;
    int unsigned m0;
    bit [31:0]   total;
    res = '0;
    if (r.command == CMD_TO_CAL) begin
      s = r.secs;
      res.second = 6'(s % 60);
      s = s / 60;
      res.minute = 6'(s % 60);
      s = s / 60;
      res.hour = 5'(s % 24);
      days = s / 24;
      y = EPOCH_YEAR;
      while (days >= days_in_year(y)) begin
        days -= days_in_year(y);
        y++;
      end
      m0 = 0;
      while (m0 < 11 && days >= days_in_month(m0, y)) begin
        days -= days_in_month(m0, y);
        m0++;
      end
      res.year = 12'(y);
      res.month = 4'(m0 + 1);
      res.day = 5'(days + 1);
      res.range_error = (y > MAX_YEAR);
    end else if (r.year < EPOCH_YEAR || r.year > MAX_YEAR || r.month < 1 || r.month > 12) begin
      res.range_error = 1'b1;
    end else begin
      total = '0;
      for (y = EPOCH_YEAR; y < r.year; y++) total += days_in_year(y);
      for (m0 = 0; m0 + 1 < r.month; m0++) total += days_in_month(m0, r.year);
      // 32-bit wrap is intended: day 0 steps back a day, oversized fields overflow
      total = (total + 32'(r.day) - 32'd1) * 32'd86400 + 32'(r.hour) * 32'd3600 +
              32'(r.minute) * 32'd60 + 32'(r.second);
      res.secs = total;
    end
    return res;
  endfunction

  function automatic cal_req_t to_cal_req(bit [31:0] secs);
    cal_req_t r;
    r = '0;
    r.command = CMD_TO_CAL;
    r.secs = secs;
    return r;
  endfunction

  function automatic cal_req_t to_secs_req(int unsigned y, int unsigned m, int unsigned d,
                                           int unsigned h, int unsigned mi, int unsigned s);
    cal_req_t r;
    r = '0;
    r.command = CMD_TO_SECS;
    r.year = 12'(y);
    r.month = 4'(m);
    r.day = 5'(d);
    r.hour = 5'(h);
    r.minute = 6'(mi);
    r.second = 6'(s);
    return r;
  endfunction

  function automatic cal_res_t date_res(int unsigned y, int unsigned m, int unsigned d,
                                        int unsigned h, int unsigned mi, int unsigned s,
                                        bit err);
    cal_res_t res;
    res = '0;
    res.year = 12'(y);
    res.month = 4'(m);
    res.day = 5'(d);
    res.hour = 5'(h);
    res.minute = 6'(mi);
    res.second = 6'(s);
    res.range_error = err;
    return res;
  endfunction

  function automatic cal_res_t secs_res(bit [31:0] secs, bit err);
    cal_res_t res;
    res = '0;
    res.secs = secs;
    res.range_error = err;
    return res;
  endfunction

  function automatic int unsigned pick_gap();
    int unsigned roll;
    roll = $urandom_range(0, 99);
    if (roll < 55) return 0;
    if (roll < 88) return $urandom_range(1, 3);
    if (roll < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 100);
  endfunction

  function automatic cal_req_t random_req();
    cal_req_t    r;
    cal_res_t    base;
    int unsigned pick;
    // unused fields carry random junk too
    r.secs = $urandom();
    r.year = 12'($urandom_range(0, 4095));
    r.month = 4'($urandom_range(0, 15));
    r.day = 5'($urandom_range(0, 31));
    r.hour = 5'($urandom_range(0, 31));
    r.minute = 6'($urandom_range(0, 63));
    r.second = 6'($urandom_range(0, 63));
    pick = $urandom_range(0, 99);
    if (pick < 50) begin
      r.command = CMD_TO_CAL;
      case ($urandom_range(0, 2))
        0: ;
        1: begin
          // a few seconds around the start of some month
          base = convert_time(to_secs_req($urandom_range(EPOCH_YEAR, MAX_YEAR),
                                          $urandom_range(1, 12), 1, 0, 0, 0));
          r.secs = base.secs + 32'($urandom_range(0, 4)) - 32'd2;
        end
        default: r.secs = 32'd4291747190 + 32'($urandom_range(0, 3220105));
      endcase
    end else begin
      r.command = CMD_TO_SECS;
      if (pick < 88) begin
        r.year = 12'($urandom_range(EPOCH_YEAR, MAX_YEAR));
        r.month = 4'($urandom_range(1, 12));
        if (pick < 80) begin
          r.day = 5'($urandom_range(1, 31));
          r.hour = 5'($urandom_range(0, 23));
          r.minute = 6'($urandom_range(0, 59));
          r.second = 6'($urandom_range(0, 59));
        end
      end
    end
    return r;
  endfunction

  task automatic send_item(cal_req_t r, cal_res_t want, int unsigned gap);
    repeat (gap) begin
      @(negedge clk);
      in_ch.valid <= 1'b0;
    end
    @(negedge clk);
    in_ch.valid         <= 1'b1;
    in_ch.command       <= r.command;
    in_ch.epoch_seconds <= r.secs;
    in_ch.year_in       <= r.year;
    in_ch.month_in      <= r.month;
    in_ch.day_in        <= r.day;
    in_ch.hour_in       <= r.hour;
    in_ch.minute_in     <= r.minute;
    in_ch.second_in     <= r.second;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    due_conversions.push_back(want);
    items_accepted++;
  endtask

  function automatic int field_err(string name, longint unsigned want, longint unsigned got);
    if (want == got) return 0;
    $error("%s: expected %0d, got %0d", name, want, got);
    return 1;
  endfunction

  // result side: random stalls, plus one long hold-off to back up the input
  initial begin
    int unsigned stall_left;
    bit          pressure_done;
    out_ch.ready = 1'b0;
    stall_left = 0;
    pressure_done = 1'b0;
    forever begin
      @(negedge clk);
      if (!pressure_done && items_accepted >= HOLD_AFTER) begin
        pressure_done = 1'b1;
        stall_left = HOLD_CYCLES;
      end else if (stall_left == 0 && !calm && $urandom_range(0, 3) == 0) begin
        stall_left = pick_gap();
      end
      if (stall_left > 0) begin
        out_ch.ready <= 1'b0;
        stall_left--;
      end else begin
        out_ch.ready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    cal_res_t got;
    cal_res_t want;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      got.secs        = out_ch.epoch_seconds_out;
      got.year        = out_ch.year_out;
      got.month       = out_ch.month_out;
      got.day         = out_ch.day_out;
      got.hour        = out_ch.hour_out;
      got.minute      = out_ch.minute_out;
      got.second      = out_ch.second_out;
      got.range_error = out_ch.range_error;
      if (due_conversions.size() == 0) begin
        $error("result arrived with no item pending");
        mismatches++;
      end else begin
        want = due_conversions.pop_front();
        mismatches += field_err("epoch_seconds_out", want.secs, got.secs) +
                      field_err("year_out", want.year, got.year) +
                      field_err("month_out", want.month, got.month) +
                      field_err("day_out", want.day, got.day) +
                      field_err("hour_out", want.hour, got.hour) +
                      field_err("minute_out", want.minute, got.minute) +
                      field_err("second_out", want.second, got.second) +
                      field_err("range_error", want.range_error, got.range_error);
      end
    end
  end

  always @(posedge clk) begin
    cycle_cnt++;
    if (cycle_cnt >= LIMIT_CYCLES) begin
      $display("unix_time_calendar_converter test failed");
      $finish;
    end
  end

  initial begin
    dir_row_t dir_rows[$];
    cal_req_t req;
    cal_res_t want;
    rst_n               = 1'b0;
    in_ch.valid         = 1'b0;
    in_ch.command       = CMD_TO_CAL;
    in_ch.epoch_seconds = '0;
    in_ch.year_in       = '0;
    in_ch.month_in      = '0;
    in_ch.day_in        = '0;
    in_ch.hour_in       = '0;
    in_ch.minute_in     = '0;
    in_ch.second_in     = '0;

    // seconds to calendar: range ends, leap rules
    dir_rows.push_back('{to_cal_req(32'd0), 1'b1, date_res(1970, 1, 1, 0, 0, 0, 1'b0)});
    dir_rows.push_back('{to_cal_req(32'hFFFF_FFFF), 1'b1, date_res(2106, 2, 7, 6, 28, 15, 1'b1)});
    dir_rows.push_back('{to_cal_req(32'd4291747199), 1'b1,
                         date_res(2105, 12, 31, 23, 59, 59, 1'b0)});
    dir_rows.push_back('{to_cal_req(32'd4291747200), 1'b1, date_res(2106, 1, 1, 0, 0, 0, 1'b1)});
    dir_rows.push_back('{to_cal_req(32'd951782400), 1'b0, '0});
    dir_rows.push_back('{to_cal_req(32'd4107542399), 1'b0, '0});
    dir_rows.push_back('{to_cal_req(32'd68169600), 1'b0, '0});
    dir_rows.push_back('{to_cal_req(32'd1709251199), 1'b0, '0});
    // calendar to seconds: range ends, then year/month errors
    dir_rows.push_back('{to_secs_req(1970, 1, 1, 0, 0, 0), 1'b1, secs_res(32'd0, 1'b0)});
    dir_rows.push_back('{to_secs_req(2105, 12, 31, 23, 59, 59), 1'b1,
                         secs_res(32'd4291747199, 1'b0)});
    dir_rows.push_back('{to_secs_req(1969, 6, 15, 12, 0, 0), 1'b1, secs_res(32'd0, 1'b1)});
    dir_rows.push_back('{to_secs_req(2106, 1, 1, 0, 0, 0), 1'b1, secs_res(32'd0, 1'b1)});
    dir_rows.push_back('{to_secs_req(2000, 0, 1, 0, 0, 0), 1'b1, secs_res(32'd0, 1'b1)});
    dir_rows.push_back('{to_secs_req(2000, 13, 1, 0, 0, 0), 1'b1, secs_res(32'd0, 1'b1)});
    dir_rows.push_back('{to_secs_req(4095, 15, 31, 31, 63, 63), 1'b1, secs_res(32'd0, 1'b1)});
    dir_rows.push_back('{to_secs_req(0, 1, 1, 0, 0, 0), 1'b1, secs_res(32'd0, 1'b1)});
    // unchecked day/time fields, including the wrap below zero
    dir_rows.push_back('{to_secs_req(1970, 1, 0, 0, 0, 0), 1'b0, '0});
    dir_rows.push_back('{to_secs_req(2000, 2, 29, 12, 34, 56), 1'b0, '0});
    dir_rows.push_back('{to_secs_req(2100, 3, 1, 0, 0, 0), 1'b0, '0});
    dir_rows.push_back('{to_secs_req(2105, 12, 31, 31, 63, 63), 1'b0, '0});
    dir_rows.push_back('{to_secs_req(2024, 2, 31, 0, 0, 0), 1'b0, '0});
    // fields of the other direction must be ignored
    req = to_cal_req(32'h8000_0000);
    req.year = 12'hFFF;
    req.month = 4'hF;
    req.day = 5'h1F;
    req.hour = 5'h1F;
    req.minute = 6'h3F;
    req.second = 6'h3F;
    dir_rows.push_back('{req, 1'b0, '0});
    req = to_secs_req(2038, 1, 19, 3, 14, 7);
    req.secs = 32'hFFFF_FFFF;
    dir_rows.push_back('{req, 1'b0, '0});

    repeat (10) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    foreach (dir_rows[i]) begin
      want = dir_rows[i].has_exp ? dir_rows[i].res : convert_time(dir_rows[i].req);
      send_item(dir_rows[i].req, want, pick_gap());
    end

    for (int unsigned n = 0; n < RANDOM_ITEMS; n++) begin
      if (n % 100 == 0) calm = ($urandom_range(0, 3) == 0);
      req = random_req();
      send_item(req, convert_time(req), calm ? 0 : pick_gap());
    end
    @(negedge clk);
    in_ch.valid <= 1'b0;

    while (due_conversions.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0) begin
      $display("unix_time_calendar_converter test passed");
    end else begin
      $display("unix_time_calendar_converter test failed");
    end
    $finish;
  end

endmodule

@@ filelist.f @@
rtl/ucc_pkg.sv
rtl/ucc_if.sv
rtl/ucc_datapath.sv
rtl/ucc_ctrl.sv
rtl/unix_time_calendar_converter.sv
sim/tb_unix_time_calendar_converter.sv
